/* rtl/obbsat_pkg.sv */
// Shared types and constants for the oriented-box separating-axis test.
// No dependencies; used by obbsat_axis and oriented_box_overlap_test_2d_unit.
package obbsat_pkg;

  // Fixed field and register widths
  localparam int FieldWidth   = 32;
  localparam int NumCorners   = 4;
  localparam int NumCoords    = 2 * NumCorners;
  localparam int NumRegs      = 8;
  localparam int RegIdxWidth  = 3;
  localparam int CfgIdxWidth  = 4;
  localparam int NumAxes      = 4;
  localparam int PipeDepth    = 5;

  // Corner that closes each edge axis, measured from corner 0
  localparam int EdgeCornerA  = 1;
  localparam int EdgeCornerB  = 3;

  // Per-stage load enables handed to each axis unit
  typedef struct packed {
    logic diff;
    logic mul;
    logic sum;
    logic span;
  } stage_en_t;

endpackage

/* rtl/obbsat_axis.sv */
// One separating axis: edge from corner 0 to corner k of one box, with the
// other box's four corners projected onto it. Depends on obbsat_pkg.
module obbsat_axis #(
  parameter int CoordWidth = 32
) (
  input  logic                         clk_i,
  input  obbsat_pkg::stage_en_t        en_i,
  input  logic signed [CoordWidth-1:0] a0_x_i,
  input  logic signed [CoordWidth-1:0] a0_y_i,
  input  logic signed [CoordWidth-1:0] ak_x_i,
  input  logic signed [CoordWidth-1:0] ak_y_i,
  input  logic signed [CoordWidth-1:0] b_x_i [obbsat_pkg::NumCorners],
  input  logic signed [CoordWidth-1:0] b_y_i [obbsat_pkg::NumCorners],
  output logic                         meet_o
);

  localparam int DW = CoordWidth + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int NC = obbsat_pkg::NumCorners;

  // Stage 1: edge vector and corner offsets from corner 0
  logic signed [DW-1:0] ex_d, ey_d, ex_q, ey_q;
  logic signed [DW-1:0] dx_d [NC];
  logic signed [DW-1:0] dy_d [NC];
  logic signed [DW-1:0] dx_q [NC];
  logic signed [DW-1:0] dy_q [NC];

  always_comb begin
    ex_d = $signed({ak_x_i[CoordWidth-1], ak_x_i}) - $signed({a0_x_i[CoordWidth-1], a0_x_i});
    ey_d = $signed({ak_y_i[CoordWidth-1], ak_y_i}) - $signed({a0_y_i[CoordWidth-1], a0_y_i});
    for (int c = 0; c < NC; c++) begin
      dx_d[c] = $signed({b_x_i[c][CoordWidth-1], b_x_i[c]})
              - $signed({a0_x_i[CoordWidth-1], a0_x_i});
      dy_d[c] = $signed({b_y_i[c][CoordWidth-1], b_y_i[c]})
              - $signed({a0_y_i[CoordWidth-1], a0_y_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.diff) begin
      ex_q <= ex_d;
      ey_q <= ey_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // Stage 2: full-width products
  logic signed [PW-1:0] lxx_d, lyy_d, lxx_q, lyy_q;
  logic signed [PW-1:0] px_d [NC];
  logic signed [PW-1:0] py_d [NC];
  logic signed [PW-1:0] px_q [NC];
  logic signed [PW-1:0] py_q [NC];

  always_comb begin
    lxx_d = ex_q * ex_q;
    lyy_d = ey_q * ey_q;
    for (int c = 0; c < NC; c++) begin
      px_d[c] = dx_q[c] * ex_q;
      py_d[c] = dy_q[c] * ey_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      lxx_q <= lxx_d;
      lyy_q <= lyy_d;
      px_q  <= px_d;
      py_q  <= py_d;
    end
  end

  // Stage 3: squared edge length and projections
  logic signed [SW-1:0] len_d, len_q;
  logic signed [SW-1:0] t_d [NC];
  logic signed [SW-1:0] t_q [NC];

  always_comb begin
    len_d = SW'(lxx_q) + SW'(lyy_q);
    for (int c = 0; c < NC; c++) begin
      t_d[c] = SW'(px_q[c]) + SW'(py_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      len_q <= len_d;
      t_q   <= t_d;
    end
  end

  // Stage 4: projected span as a two-level min/max tree
  logic signed [SW-1:0] min01, min23, max01, max23;
  logic signed [SW-1:0] tmin_d, tmax_d, tmin_q, tmax_q, len2_q;

  always_comb begin
    min01  = (t_q[1] < t_q[0]) ? t_q[1] : t_q[0];
    min23  = (t_q[3] < t_q[2]) ? t_q[3] : t_q[2];
    max01  = (t_q[1] > t_q[0]) ? t_q[1] : t_q[0];
    max23  = (t_q[3] > t_q[2]) ? t_q[3] : t_q[2];
    tmin_d = (min23 < min01) ? min23 : min01;
    tmax_d = (max23 > max01) ? max23 : max01;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.span) begin
      tmin_q <= tmin_d;
      tmax_q <= tmax_d;
      len2_q <= len_q;
    end
  end

  // Spans meet unless the span lies wholly past the edge or before corner 0
  assign meet_o = !((tmin_q > len2_q) || tmax_q[SW-1]);

endmodule

/* rtl/oriented_box_overlap_test_2d_unit.sv */
// Top level of the 2D oriented-box overlap test: config registers, valid
// chain and four axis units. Depends on obbsat_pkg and obbsat_axis.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   command  | start_i / busy_o           | box_c0_x_i .. box_c3_y_i
//   result   | done_o (one-cycle strobe)  | overlap_o
//   config   | cfg_valid_i / cfg_ready_o  | cfg_idx_i, cfg_data_i
//
// One beat enters per cycle; busy_o stays low. The result of an accepted beat
// appears on done_o/overlap_o after passing the six register stages: input
// capture, differences, products, sums, min/max, final AND.
// Reset clears the valid chain and the reference corners to zero.
// The receiver cannot stall, so the pipeline always advances.
module oriented_box_overlap_test_2d_unit #(
  parameter int CoordWidth = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [obbsat_pkg::FieldWidth-1:0]   box_c0_x_i,
  input  logic [obbsat_pkg::FieldWidth-1:0]   box_c0_y_i,
  input  logic [obbsat_pkg::FieldWidth-1:0]   box_c1_x_i,
  input  logic [obbsat_pkg::FieldWidth-1:0]   box_c1_y_i,
  input  logic [obbsat_pkg::FieldWidth-1:0]   box_c2_x_i,
  input  logic [obbsat_pkg::FieldWidth-1:0]   box_c2_y_i,
  input  logic [obbsat_pkg::FieldWidth-1:0]   box_c3_x_i,
  input  logic [obbsat_pkg::FieldWidth-1:0]   box_c3_y_i,
  output logic                                done_o,
  output logic                                overlap_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [obbsat_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [obbsat_pkg::FieldWidth-1:0]   cfg_data_i
);

  localparam int NC = obbsat_pkg::NumCorners;
  localparam int NR = obbsat_pkg::NumRegs;

  logic accept;
  logic cfg_we;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Reference corner registers; drop writes past the register list
  logic [NR-1:0][obbsat_pkg::FieldWidth-1:0] ref_d, ref_q;

  always_comb begin
    ref_d = ref_q;
    if (cfg_we && (cfg_idx_i < obbsat_pkg::CfgIdxWidth'(NR))) begin
      ref_d[cfg_idx_i[obbsat_pkg::RegIdxWidth-1:0]] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else begin
      ref_q <= ref_d;
    end
  end

  // Valid chain: one bit per stage, advances every cycle
  logic [obbsat_pkg::PipeDepth-1:0] v_d, v_q;
  logic                             done_d, done_q;

  assign v_d = {v_q[obbsat_pkg::PipeDepth-2:0], accept};

  // Capture the candidate corners on accept
  logic [obbsat_pkg::NumCoords-1:0][CoordWidth-1:0] box_d, box_q;

  always_comb begin
    box_d[0] = box_c0_x_i[CoordWidth-1:0];
    box_d[1] = box_c0_y_i[CoordWidth-1:0];
    box_d[2] = box_c1_x_i[CoordWidth-1:0];
    box_d[3] = box_c1_y_i[CoordWidth-1:0];
    box_d[4] = box_c2_x_i[CoordWidth-1:0];
    box_d[5] = box_c2_y_i[CoordWidth-1:0];
    box_d[6] = box_c3_x_i[CoordWidth-1:0];
    box_d[7] = box_c3_y_i[CoordWidth-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      box_q <= box_d;
    end
  end

  // Split both boxes into signed corner coordinates
  logic signed [CoordWidth-1:0] rx [NC];
  logic signed [CoordWidth-1:0] ry [NC];
  logic signed [CoordWidth-1:0] bx [NC];
  logic signed [CoordWidth-1:0] by [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      rx[c] = $signed(ref_q[2*c][CoordWidth-1:0]);
      ry[c] = $signed(ref_q[2*c+1][CoordWidth-1:0]);
      bx[c] = $signed(box_q[2*c]);
      by[c] = $signed(box_q[2*c+1]);
    end
  end

  obbsat_pkg::stage_en_t en;

  assign en.diff = v_q[0];
  assign en.mul  = v_q[1];
  assign en.sum  = v_q[2];
  assign en.span = v_q[3];

  // Axes on each box's edges from corner 0 to EdgeCornerA and EdgeCornerB
  logic [obbsat_pkg::NumAxes-1:0] meet;

  obbsat_axis #(.CoordWidth(CoordWidth)) u_axis_ref_a (
    .clk_i (clk_i), .en_i (en),
    .a0_x_i(rx[0]), .a0_y_i(ry[0]),
    .ak_x_i(rx[obbsat_pkg::EdgeCornerA]), .ak_y_i(ry[obbsat_pkg::EdgeCornerA]),
    .b_x_i (bx), .b_y_i (by), .meet_o(meet[0])
  );

  obbsat_axis #(.CoordWidth(CoordWidth)) u_axis_ref_b (
    .clk_i (clk_i), .en_i (en),
    .a0_x_i(rx[0]), .a0_y_i(ry[0]),
    .ak_x_i(rx[obbsat_pkg::EdgeCornerB]), .ak_y_i(ry[obbsat_pkg::EdgeCornerB]),
    .b_x_i (bx), .b_y_i (by), .meet_o(meet[1])
  );

  obbsat_axis #(.CoordWidth(CoordWidth)) u_axis_box_a (
    .clk_i (clk_i), .en_i (en),
    .a0_x_i(bx[0]), .a0_y_i(by[0]),
    .ak_x_i(bx[obbsat_pkg::EdgeCornerA]), .ak_y_i(by[obbsat_pkg::EdgeCornerA]),
    .b_x_i (rx), .b_y_i (ry), .meet_o(meet[2])
  );

  obbsat_axis #(.CoordWidth(CoordWidth)) u_axis_box_b (
    .clk_i (clk_i), .en_i (en),
    .a0_x_i(bx[0]), .a0_y_i(by[0]),
    .ak_x_i(bx[obbsat_pkg::EdgeCornerB]), .ak_y_i(by[obbsat_pkg::EdgeCornerB]),
    .b_x_i (rx), .b_y_i (ry), .meet_o(meet[3])
  );

  // Final stage: overlap only if every axis fails to separate
  logic overlap_d, overlap_q;

  assign overlap_d = &meet;
  assign done_d    = v_q[obbsat_pkg::PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= v_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      overlap_q <= overlap_d;
    end
  end

  assign done_o    = done_q;
  assign overlap_o = overlap_q;

`ifndef ASSERT_OFF
  // Every accepted beat yields a result strobe on done_o
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("accepted beat produced no result");

  // No result without a matching beat accepted earlier
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 6))
    else $error("result strobe without an accepted beat");

  // Reference corners change only on a config write
  a_ref_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we |=> $stable(ref_q))
    else $error("reference corners changed without a config write");
`endif

endmodule
